### src/mdpc_pkg.sv
package mdpc_pkg;

    // Field widths
    localparam int COORD_BITS  = 16;
    localparam int RADIUS_BITS = 14;
    localparam int PT_W        = COORD_BITS + 1;   // emitted point coordinate
    localparam int DIAM_W      = RADIUS_BITS + 1;  // 2r
    localparam int OFFX_W      = RADIUS_BITS + 2;  // x offset, signed (starts at r-1, may be -1)
    localparam int OFFY_W      = RADIUS_BITS + 1;  // y offset, unsigned
    localparam int STEP_W      = RADIUS_BITS + 2;  // tx / ty
    localparam int ERR_W       = RADIUS_BITS + 3;  // error term, signed
    // Internal width for point arithmetic before truncation to PT_W
    localparam int CALC_W      = (PT_W > RADIUS_BITS + 3) ? PT_W : RADIUS_BITS + 3;

    // Eight mirrored points per advance
    localparam int NPTS  = 8;
    localparam int IDX_W = $clog2(NPTS);
    typedef logic [IDX_W-1:0] idx_t;
    localparam idx_t IDX_LAST = idx_t'(NPTS - 1);

    // Input operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_OUT
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic start;      // load a new circle
        logic emit_pt;    // load output word with point idx
        logic emit_done;  // load output word with done marker, drop circle
        logic step;       // advance error terms one octant step
        idx_t idx;
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic active;
        logic finished;   // x < y
    } sts_t;

endpackage

### src/mdpc_datapath.sv
module mdpc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mdpc_pkg::cmd_t                      cmd,
    output mdpc_pkg::sts_t                      sts,
    input  logic signed [mdpc_pkg::COORD_BITS-1:0] s_center_x,
    input  logic signed [mdpc_pkg::COORD_BITS-1:0] s_center_y,
    input  logic        [mdpc_pkg::RADIUS_BITS-1:0] s_radius,
    output logic signed [mdpc_pkg::PT_W-1:0]    m_point_x,
    output logic signed [mdpc_pkg::PT_W-1:0]    m_point_y,
    output logic                                m_point_valid,
    output logic                                m_last,
    output logic                                m_done_res
);
    import mdpc_pkg::*;

    logic signed [COORD_BITS-1:0] ctr_x_reg, ctr_y_reg;
    logic        [DIAM_W-1:0]     diam_reg;
    logic signed [OFFX_W-1:0]     off_x_reg;
    logic        [OFFY_W-1:0]     off_y_reg;
    logic        [STEP_W-1:0]     step_tx_reg, step_ty_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic                         active_reg;

    logic signed [PT_W-1:0] pt_x_reg, pt_y_reg;
    logic                   pt_valid_reg, last_reg, done_reg;

    logic signed [CALC_W-1:0] cx, cy, ex, ey, sel_a, sel_b, px, py;
    logic signed [ERR_W-1:0]  err_mid, err_new, err_start;
    logic        [STEP_W-1:0] ty_new, tx_new;
    logic        [OFFY_W-1:0] y_new;
    logic signed [OFFX_W-1:0] x_new;
    logic                     y_step, x_step;

    // Mirrored point select: bit2 swaps x/y, bit1 negates along x, bit0 sign along y
    always_comb begin
        cx    = CALC_W'(ctr_x_reg);
        cy    = CALC_W'(ctr_y_reg);
        ex    = CALC_W'(off_x_reg);
        ey    = $signed({{(CALC_W-OFFY_W){1'b0}}, off_y_reg});
        sel_a = cmd.idx[2] ? ey : ex;
        sel_b = cmd.idx[2] ? ex : ey;
        px    = cmd.idx[1] ? cx - sel_a : cx + sel_a;
        py    = cmd.idx[0] ? cy + sel_b : cy - sel_b;
    end

    // Error term update: y step first, x step tests the updated error
    always_comb begin
        y_step  = (err_reg <= 0);
        err_mid = y_step ? err_reg + $signed({1'b0, step_ty_reg}) : err_reg;
        ty_new  = y_step ? step_ty_reg + STEP_W'(2) : step_ty_reg;
        y_new   = y_step ? off_y_reg + OFFY_W'(1) : off_y_reg;
        x_step  = (err_mid > 0);
        tx_new  = x_step ? step_tx_reg + STEP_W'(2) : step_tx_reg;
        x_new   = x_step ? off_x_reg - OFFX_W'(1) : off_x_reg;
        err_new = x_step ? err_mid + $signed({1'b0, tx_new})
                           - $signed({{(ERR_W-DIAM_W){1'b0}}, diam_reg})
                         : err_mid;
        err_start = ERR_W'(1) - $signed({{(ERR_W-DIAM_W){1'b0}}, s_radius, 1'b0});
    end

    // Circle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_x_reg   <= '0;
            ctr_y_reg   <= '0;
            diam_reg    <= '0;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            step_tx_reg <= '0;
            step_ty_reg <= '0;
            err_reg     <= '0;
            active_reg  <= 1'b0;
        end else if (cmd.start) begin
            ctr_x_reg   <= s_center_x;
            ctr_y_reg   <= s_center_y;
            diam_reg    <= {s_radius, 1'b0};
            off_x_reg   <= $signed({2'b00, s_radius}) - OFFX_W'(1);
            off_y_reg   <= '0;
            step_tx_reg <= STEP_W'(1);
            step_ty_reg <= STEP_W'(1);
            err_reg     <= err_start;
            active_reg  <= 1'b1;
        end else if (cmd.emit_done) begin
            active_reg <= 1'b0;
        end else if (cmd.step) begin
            off_x_reg   <= x_new;
            off_y_reg   <= y_new;
            step_tx_reg <= tx_new;
            step_ty_reg <= ty_new;
            err_reg     <= err_new;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (cmd.emit_done) begin
            pt_x_reg     <= '0;
            pt_y_reg     <= '0;
            pt_valid_reg <= 1'b0;
            last_reg     <= 1'b1;
            done_reg     <= 1'b1;
        end else if (cmd.emit_pt) begin
            pt_x_reg     <= px[PT_W-1:0];
            pt_y_reg     <= py[PT_W-1:0];
            pt_valid_reg <= 1'b1;
            last_reg     <= (cmd.idx == IDX_LAST);
            done_reg     <= 1'b0;
        end
    end

    assign sts.active   = active_reg;
    assign sts.finished = (off_x_reg < $signed({1'b0, off_y_reg}));

    assign m_point_x     = pt_x_reg;
    assign m_point_y     = pt_y_reg;
    assign m_point_valid = pt_valid_reg;
    assign m_last        = last_reg;
    assign m_done_res    = done_reg;

endmodule

### src/mdpc_ctrl.sv
module mdpc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_op,
    output logic           m_valid,
    input  logic           m_ready,
    input  mdpc_pkg::sts_t sts,
    output mdpc_pkg::cmd_t cmd
);
    import mdpc_pkg::*;

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;
    logic   done_reg, done_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = done_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_START) begin
                        cmd.start = 1'b1;
                    end else if (!sts.active || sts.finished) begin
                        cmd.emit_done = 1'b1;
                        done_next     = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        cmd.emit_pt = 1'b1;
                        cmd.idx     = '0;
                        idx_next    = '0;
                        done_next   = 1'b0;
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (done_reg) begin
                        state_next = ST_IDLE;
                    end else if (idx_reg == IDX_LAST) begin
                        cmd.step   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next    = idx_reg + 1'b1;
                        cmd.emit_pt = 1'b1;
                        cmd.idx     = idx_next;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // One word in flight: never accepting while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while result pending");

    // Point index steps by one on each taken point word
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_ready && !done_reg && idx_reg != IDX_LAST)
        |=> (idx_reg == idx_t'($past(idx_reg) + 1'b1)))
        else $error("point index skipped");

    // Terms advance only after the eighth point of a run
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (idx_reg == IDX_LAST && !done_reg && m_ready))
        else $error("term update outside end of run");

    // A start never coincides with output activity
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (state_reg == ST_IDLE && !cmd.emit_pt && !cmd.emit_done))
        else $error("start issued while busy");

endmodule

### src/midpoint_circle_outline_core.sv
// Midpoint circle outline generator. A start word (op = 0) loads the center and
// radius and returns nothing. Each advance word (op = 1) returns the eight
// octant-mirrored points of the current step, the eighth marked last, one word
// per cycle while m_ready is high, from a single output register, after which
// the error terms are updated in the cycle the eighth word is taken. One word is
// handled at a time, so input ready is low while a result is pending. An advance
// with no circle loaded, or past the end of the circle, returns a single word
// with point_valid low, last and done_res high, and drops the circle.
module midpoint_circle_outline_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_op,
    input  logic signed [mdpc_pkg::COORD_BITS-1:0]  s_center_x,
    input  logic signed [mdpc_pkg::COORD_BITS-1:0]  s_center_y,
    input  logic        [mdpc_pkg::RADIUS_BITS-1:0] s_radius,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [mdpc_pkg::PT_W-1:0]        m_point_x,
    output logic signed [mdpc_pkg::PT_W-1:0]        m_point_y,
    output logic                                    m_point_valid,
    output logic                                    m_last,
    output logic                                    m_done_res
);
    import mdpc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mdpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mdpc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_valid (m_point_valid),
        .m_last        (m_last),
        .m_done_res    (m_done_res)
    );

endmodule
